FILE: hdl/assert_macros.svh
// assertion macros shared by the decoder rtl
// expects signals named clock and reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pct_pkg.sv
// types, character constants and hex helper for the percent decoder
// no dependencies
`timescale 1ns / 1ps

package pct_pkg;

   localparam logic [7:0] PctChar   = 8'h25;
   localparam logic [7:0] SlashChar = 8'h2F;
   localparam logic [7:0] TwoChar   = 8'h32;
   localparam logic [7:0] LowFChar  = 8'h66;
   localparam logic [7:0] ZeroChar  = 8'h30;

   // escape match progress
   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_PCT   = 2'd1,
      PHASE_DIGIT = 2'd2
   } phase_type;

   // up to three output characters caused by one request
   typedef struct packed {
      logic [2:0][7:0] chars;
      logic [1:0]      count;
      logic            done;
   } burst_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: hdl/percent_decoder.sv
// top level of the streaming url percent decoder
// depends on pct_pkg, pct_decode, pct_burst and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   in_byte, keep_slash, string_end
//  rsp_      out        rsp_valid/rsp_stall   out_byte, run_last, string_done
//
// a request that yields zero or one character does not hold up the next, so
// plain text streams at one byte a cycle while rsp_stall is low; a request
// that yields n characters holds the result register until all n are taken.
// a request passes the request register, then the result register. reset
// clears the valid flags and the match state. a stalled result register backs
// up into the request register and then stalls the request side.

module percent_decoder import pct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_keep_slash,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       keep_ff, keep_in;
   logic       end_ff,  end_in;
   phase_type  phase_ff, phase_in;
   logic [2:0] digit_ff, digit_in;

   burst_type  burst;
   phase_type  phase_next;
   logic [2:0] digit_next;
   logic       free;
   logic       load;
   logic       accept;

   assign load      = in_valid_ff && free;
   assign req_stall = in_valid_ff && !free;
   assign accept    = req_valid && !req_stall;

   // request register
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      keep_in     = keep_ff;
      end_in      = end_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         byte_in     = req_in_byte;
         keep_in     = req_keep_slash;
         end_in      = req_string_end;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // match state advances when a request moves to the result register
   assign phase_in = load ? phase_next : phase_ff;
   assign digit_in = load ? digit_next : digit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_IDLE;
         digit_ff    <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         digit_ff    <= digit_in;
      end
      byte_ff <= byte_in;
      keep_ff <= keep_in;
      end_ff  <= end_in;
   end

   pct_decode u_decode (
      .in_byte    (byte_ff),
      .keep_slash (keep_ff),
      .string_end (end_ff),
      .phase      (phase_ff),
      .digit      (digit_ff),
      .burst      (burst),
      .phase_next (phase_next),
      .digit_next (digit_next)
   );

   pct_burst u_burst (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .burst           (burst),
      .free            (free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

   // checks
   `PCT_ASSERT_NEXT(a_end_clears_phase, load && end_ff, phase_ff == PHASE_IDLE, "phase not cleared at string end")
   `PCT_ASSERT_NEXT(a_load_shows_result, load && burst.count != 2'd0, rsp_valid, "loaded burst not presented")
   `PCT_ASSERT_NOW(a_end_has_result, load && end_ff, burst.count != 2'd0, "string end produced no character")
   `PCT_ASSERT_NOW(a_stall_needs_item, req_stall, in_valid_ff && rsp_valid, "request stalled without backlog")

endmodule

FILE: hdl/pct_decode.sv
// combinational escape matcher: one request to a burst of characters
// depends on pct_pkg
`timescale 1ns / 1ps

module pct_decode import pct_pkg::*; (
   input  logic [7:0] in_byte,
   input  logic       keep_slash,
   input  logic       string_end,
   input  phase_type  phase,
   input  logic [2:0] digit,
   output burst_type  burst,
   output phase_type  phase_next,
   output logic [2:0] digit_next
);

   hex_type    hex;
   logic [7:0] value;
   logic [7:0] digit_char;
   logic [7:0] new_digit_char;
   logic [1:0] n_pre;

   assign hex            = hex_decode(in_byte);
   assign value          = {1'b0, digit, hex.value};
   assign digit_char     = ZeroChar | {5'd0, digit};
   // first digit taken by this request, shown again on a flush
   assign new_digit_char = ZeroChar | {5'd0, hex.value[2:0]};

   // match step, then end-of-string flush
   always_comb begin
      burst.chars = '0;
      n_pre       = 2'd0;
      phase_next  = PHASE_IDLE;
      digit_next  = digit;
      unique case (phase)
         PHASE_PCT: begin
            if (hex.ok && !hex.value[3]) begin
               digit_next = hex.value[2:0];
               phase_next = PHASE_DIGIT;
            end else if (in_byte == PctChar) begin
               burst.chars[0] = PctChar;
               n_pre          = 2'd1;
               phase_next     = PHASE_PCT;
            end else begin
               burst.chars[0] = PctChar;
               burst.chars[1] = in_byte;
               n_pre          = 2'd2;
            end
         end
         PHASE_DIGIT: begin
            if (hex.ok) begin
               if (keep_slash && value == SlashChar) begin
                  burst.chars[0] = PctChar;
                  burst.chars[1] = TwoChar;
                  burst.chars[2] = LowFChar;
                  n_pre          = 2'd3;
               end else begin
                  burst.chars[0] = value;
                  n_pre          = 2'd1;
               end
            end else if (in_byte == PctChar) begin
               burst.chars[0] = PctChar;
               burst.chars[1] = digit_char;
               n_pre          = 2'd2;
               phase_next     = PHASE_PCT;
            end else begin
               burst.chars[0] = PctChar;
               burst.chars[1] = digit_char;
               burst.chars[2] = in_byte;
               n_pre          = 2'd3;
            end
         end
         default: begin
            if (in_byte == PctChar) begin
               phase_next = PHASE_PCT;
            end else begin
               burst.chars[0] = in_byte;
               n_pre          = 2'd1;
            end
         end
      endcase

      burst.count = n_pre;
      burst.done  = string_end;
      if (string_end) begin
         if (phase_next == PHASE_PCT) begin
            // at most two characters precede a held percent sign
            burst.chars[n_pre] = PctChar;
            burst.count        = n_pre + 2'd1;
         end else if (phase_next == PHASE_DIGIT) begin
            // a fresh digit means nothing else was emitted
            burst.chars[0] = PctChar;
            burst.chars[1] = new_digit_char;
            burst.count    = 2'd2;
         end
         phase_next = PHASE_IDLE;
         digit_next = 3'd0;
      end
   end

endmodule

FILE: hdl/pct_burst.sv
// result register: holds one burst and shifts it out a character a cycle while rsp_stall is low
// depends on pct_pkg
`timescale 1ns / 1ps

module pct_burst import pct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  burst_type  burst,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_done
);

   logic [2:0][7:0] chars_ff, chars_in;
   logic [1:0]      count_ff, count_in;
   logic            done_ff,  done_in;
   logic            take;

   assign take = (count_ff != 2'd0) && !rsp_stall;
   assign free = (count_ff == 2'd0) || (count_ff == 2'd1 && take);

   // load a new burst or shift one character out
   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      done_in  = done_ff;
      if (load) begin
         chars_in = burst.chars;
         count_in = burst.count;
         done_in  = burst.done;
      end else if (take) begin
         chars_in = {8'd0, chars_ff[2], chars_ff[1]};
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      chars_ff <= chars_in;
      done_ff  <= done_in;
   end

   assign rsp_valid       = (count_ff != 2'd0);
   assign rsp_out_byte    = chars_ff[0];
   assign rsp_run_last    = (count_ff == 2'd1);
   assign rsp_string_done = (count_ff == 2'd1) && done_ff;

endmodule

FILE: tb/sv/pct_stream_checker.sv
// request/result checker for the percent decoder: predicts and compares characters
// depends on pct_pkg for the character constants and the match phase type
`timescale 1ns / 1ps

module pct_stream_checker import pct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_keep_slash,
   input  logic       req_string_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_run_last,
   input  logic       rsp_string_done,
   output int         fail_count,
   output int         pending
);

   typedef struct packed {
      logic [7:0] ch;
      logic       run_last;
      logic       done;
   } out_char_type;

   out_char_type expected_chars[$];
   phase_type    phase = PHASE_IDLE;
   logic [2:0]   held  = 3'd0;

   initial fail_count = 0;
   initial pending = 0;

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 20) begin
         $display("%0t ns mismatch: %s", $time, msg);
      end
   endtask

   // escape matcher: turns one request into the characters it releases
   task automatic decode_request(input logic [7:0] ch, input logic path, input logic fin);
      logic [7:0]   burst[$];
      logic         is_hex;
      logic [3:0]   hv;
      logic [7:0]   val;
      logic [7:0]   digit_ch;
      out_char_type c;
      is_hex   = 1'b1;
      hv       = 4'd0;
      digit_ch = ZeroChar + {5'd0, held};
      if (ch >= 8'h30 && ch <= 8'h39) begin
         hv = 4'(ch - 8'h30);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         hv = 4'(ch - 8'h61 + 8'd10);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         hv = 4'(ch - 8'h41 + 8'd10);
      end else begin
         is_hex = 1'b0;
      end

      case (phase)
         PHASE_PCT: begin
            if (is_hex && hv <= 4'd7) begin
               held  = hv[2:0];
               phase = PHASE_DIGIT;
            end else if (ch == PctChar) begin
               burst.insert(burst.size(), PctChar);
            end else begin
               burst.insert(burst.size(), PctChar);
               burst.insert(burst.size(), ch);
               phase = PHASE_IDLE;
            end
         end
         PHASE_DIGIT: begin
            if (is_hex) begin
               val = {1'b0, held, hv};
               // a decoded slash stays escaped in path mode
               if (path && val == SlashChar) begin
                  burst.insert(burst.size(), PctChar);
                  burst.insert(burst.size(), TwoChar);
                  burst.insert(burst.size(), LowFChar);
               end else begin
                  burst.insert(burst.size(), val);
               end
               phase = PHASE_IDLE;
            end else if (ch == PctChar) begin
               burst.insert(burst.size(), PctChar);
               burst.insert(burst.size(), digit_ch);
               phase = PHASE_PCT;
            end else begin
               burst.insert(burst.size(), PctChar);
               burst.insert(burst.size(), digit_ch);
               burst.insert(burst.size(), ch);
               phase = PHASE_IDLE;
            end
         end
         default: begin
            if (ch == PctChar) begin
               phase = PHASE_PCT;
            end else begin
               burst.insert(burst.size(), ch);
               phase = PHASE_IDLE;
            end
         end
      endcase

      // end of string flushes whatever is still held
      if (fin) begin
         if (phase == PHASE_PCT) begin
            burst.insert(burst.size(), PctChar);
         end else if (phase == PHASE_DIGIT) begin
            burst.insert(burst.size(), PctChar);
            burst.insert(burst.size(), ZeroChar + {5'd0, held});
         end
         phase = PHASE_IDLE;
         held  = 3'd0;
      end

      foreach (burst[i]) begin
         c.ch       = burst[i];
         c.run_last = (i == burst.size() - 1);
         c.done     = c.run_last && fin;
         expected_chars.insert(expected_chars.size(), c);
      end
   endtask

   // sample both channels at the clock edge
   always @(posedge clock) begin
      out_char_type want;
      if (reset) begin
         expected_chars.delete();
         phase = PHASE_IDLE;
         held  = 3'd0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_request(req_in_byte, req_keep_slash, req_string_end);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("character %h with nothing expected", rsp_out_byte));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_byte !== want.ch) begin
                  report_mismatch($sformatf("out_byte %h, expected %h", rsp_out_byte, want.ch));
               end
               if (rsp_run_last !== want.run_last) begin
                  report_mismatch($sformatf("run_last %b, expected %b for %h",
                                            rsp_run_last, want.run_last, want.ch));
               end
               if (rsp_string_done !== want.done) begin
                  report_mismatch($sformatf("string_done %b, expected %b for %h",
                                            rsp_string_done, want.done, want.ch));
               end
            end
         end
      end
      pending <= expected_chars.size();
   end

endmodule

FILE: tb/sv/tb.sv
// testbench top for percent_decoder: clock, reset, request stimulus, result back pressure and verdict
// depends on pct_pkg, percent_decoder and pct_stream_checker
`timescale 1ns / 1ps

module tb import pct_pkg::*;;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte    = 8'h00;
   logic       req_keep_slash = 1'b0;
   logic       req_string_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_string_done;

   int fail_count;
   int pending;
   int sent_count = 0;
   bit steady     = 1'b0;

   always #1 clock = ~clock;

   percent_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_keep_slash  (req_keep_slash),
      .req_string_end  (req_string_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done)
   );

   pct_stream_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_keep_slash  (req_keep_slash),
      .req_string_end  (req_string_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_done (rsp_string_done),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
      if (v < 4'd10) return 8'h30 + {4'd0, v};
      return (upper ? 8'h41 : 8'h61) + {4'd0, v} - 8'd10;
   endfunction

   // present one request and hold it until accepted
   task automatic send_request(input logic [7:0] b, input logic slash, input logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= b;
      req_keep_slash <= slash;
      req_string_end <= fin;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   // hold off the sender until every expected character is out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // result side back pressure, with quiet stretches
   initial begin
      int r;
      forever begin
         r = $urandom_range(0, 99);
         rsp_stall <= 1'b0;
         if (r < 10) begin
            repeat ($urandom_range(50, 200)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // run limit
   initial begin
      #2_000_000;
      $display("percent_decoder regression: fail");
      $finish;
   end

   initial begin
      logic [7:0] text[$];
      logic       slash;
      int         segs;
      int         r;
      logic [3:0] lo;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed strings
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hFF, 1'b1, 1'b1);
      // decoded slash in path mode, upper case second digit
      send_request(PctChar, 1'b1, 1'b0);
      send_request(8'h32, 1'b1, 1'b0);
      send_request(8'h46, 1'b1, 1'b1);
      // decoded slash outside path mode
      send_request(PctChar, 1'b0, 1'b0);
      send_request(8'h32, 1'b0, 1'b0);
      send_request(8'h66, 1'b0, 1'b0);
      // highest escape value
      send_request(PctChar, 1'b0, 1'b0);
      send_request(8'h37, 1'b0, 1'b0);
      send_request(8'h66, 1'b0, 1'b1);
      // first digit out of range
      send_request(PctChar, 1'b0, 1'b0);
      send_request(8'h38, 1'b0, 1'b0);
      // second digit not hex
      send_request(PctChar, 1'b1, 1'b0);
      send_request(8'h34, 1'b1, 1'b0);
      send_request(8'h47, 1'b1, 1'b1);
      // second percent while one is held, then lowest escape value
      send_request(PctChar, 1'b0, 1'b0);
      send_request(PctChar, 1'b0, 1'b0);
      send_request(8'h30, 1'b0, 1'b0);
      send_request(8'h30, 1'b0, 1'b1);
      // percent after a held digit, then flush of a lone percent
      send_request(PctChar, 1'b0, 1'b0);
      send_request(8'h34, 1'b0, 1'b0);
      send_request(PctChar, 1'b0, 1'b1);
      // flush of percent and digit
      send_request(PctChar, 1'b1, 1'b0);
      send_request(8'h35, 1'b1, 1'b1);

      drain_results();

      // random strings of plain bytes, well-formed escapes and broken ones
      while (sent_count < 470) begin
         text.delete();
         steady = ($urandom_range(0, 7) == 0);
         slash  = 1'($urandom_range(0, 1));
         segs   = $urandom_range(1, 10);
         repeat (segs) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               text.insert(text.size(), 8'($urandom_range(0, 255)));
            end else if (r < 75) begin
               lo = (r < 48) ? 4'hF : 4'($urandom_range(0, 15));
               text.insert(text.size(), PctChar);
               text.insert(text.size(),
                           (r < 48) ? TwoChar : 8'h30 + 8'($urandom_range(0, 7)));
               text.insert(text.size(), hex_char(lo, 1'($urandom_range(0, 1))));
            end else if (r < 85) begin
               text.insert(text.size(), PctChar);
               text.insert(text.size(), 8'($urandom_range(0, 255)));
            end else if (r < 93) begin
               text.insert(text.size(), PctChar);
               text.insert(text.size(), 8'h30 + 8'($urandom_range(0, 7)));
               text.insert(text.size(), 8'($urandom_range(0, 255)));
            end else if (r < 97) begin
               text.insert(text.size(), PctChar);
            end else begin
               text.insert(text.size(), PctChar);
               text.insert(text.size(), 8'h30 + 8'($urandom_range(0, 7)));
            end
         end
         foreach (text[i]) begin
            send_request(text[i], ($urandom_range(0, 9) == 0) ? ~slash : slash,
                         i == text.size() - 1);
         end
         if ($urandom_range(0, 19) == 0) begin
            drain_results();
         end
      end

      // wait out the last characters, then give the verdict
      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("percent_decoder regression: pass");
      end else begin
         $display("percent_decoder regression: fail");
      end
      $finish;
   end

endmodule
